FILE: sv/lfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared constants, codes and helpers for the LED frame compositor.
// ----------------------------------------------------------------------------
package lfc_pkg;

  // Store geometry
  localparam int PIXELS = 512;
  localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // Request kinds
  localparam logic KIND_BLEND   = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  // Blend modes
  localparam logic [1:0] MODE_REPLACE = 2'd0;
  localparam logic [1:0] MODE_ADD     = 2'd1;
  localparam logic [1:0] MODE_MAX     = 2'd2;
  localparam logic [1:0] MODE_OVER    = 2'd3;

  // Rounding bias for a divide by 255
  localparam logic [15:0] ROUND_BIAS = 16'd127;

  // floor(x / 255) for x <= 65279: (x + (x >> 8) + 1) >> 8.
  // Callers add the rounding bias beforehand; results here stay below 256.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage
`default_nettype wire

FILE: sv/led_frame_compositor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_frame_compositor_unit
// Per-LED RGBA store with replace/add/max/over blending and scaled readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: a blend
//   (kind 0) folds the source RGBA into the addressed pixel, a readout
//   (kind 1) returns the pixel scaled by brightness and clears it to zero.
//   Output channel (out_valid_o/out_ready_i) carries one result per readout;
//   blends produce none.
//   Each request passes in order through accept with memory read, product
//   stage, second product stage, then write-back, the two product stages
//   holding the multiplies. With only one request in flight, the next
//   request is taken in the cycle after write-back. A readout's result is
//   loaded into the output register as it leaves write-back.
//   After reset the memory is swept to zero, one pixel per cycle, while
//   in_ready_o stays low.
//   The result sits in an output register, so the block keeps accepting
//   blends while a result waits; a readout whose result cannot be loaded
//   holds in write-back until the receiver takes the pending one.
//   Only one request is in flight, so a write-back never overlaps a read of
//   the same pixel and no forwarding is needed.
// ----------------------------------------------------------------------------
module led_frame_compositor_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [8:0] pixel_index_i,
  input  wire logic [1:0] blend_mode_i,
  input  wire logic [7:0] src_red_i,
  input  wire logic [7:0] src_green_i,
  input  wire logic [7:0] src_blue_i,
  input  wire logic [7:0] src_alpha_i,
  input  wire logic [7:0] brightness_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [8:0]      out_index_o,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o
);
  import lfc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_WRITE
  } state_e;

  // Pixel memory: {alpha, blue, green, red}
  logic [31:0]       mem_q [PIXELS];
  logic [31:0]       rdata_q;
  logic              mem_we;
  logic [PIX_AW-1:0] mem_waddr;
  logic [31:0]       mem_wdata;

  state_e            state_q, state_d;
  logic [PIX_AW-1:0] clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic [8:0]        out_index_q, out_index_d;
  logic [7:0]        out_ch_q [3];
  logic [7:0]        out_ch_d [3];

  // Captured request
  logic              kind_q;
  logic [8:0]        index_q;
  logic [PIX_AW-1:0] addr_q;
  logic              hit_q;
  logic [1:0]        mode_q;
  logic [7:0]        src_q [3];
  logic [7:0]        alpha_q;
  logic [7:0]        bright_q;

  // Product stages
  logic [15:0]       prod_sa_q  [3];
  logic [15:0]       prod_old_q [3];
  logic [15:0]       prod_olda_q;
  logic [7:0]        p_q        [3];

  logic              accept;
  logic              load_out;
  logic              advance;
  logic [7:0]        old_ch [3];
  logic [7:0]        old_a;
  logic [7:0]        mul_op;
  logic [7:0]        res_ch [3];
  logic [7:0]        res_a;
  logic [7:0]        rd_ch  [3];
  logic [15:0]       a255;

  assign accept   = in_valid_i && in_ready_o;
  assign load_out = !out_valid_q || out_ready_i;
  assign advance  = (kind_q == KIND_BLEND) || load_out;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      old_ch[c] = rdata_q[8*c +: 8];
    end
    old_a  = rdata_q[31:24];
    // 255 - a is the bit inverse of a for 8-bit fractions
    mul_op = (kind_q == KIND_READOUT) ? bright_q : ~alpha_q;
    a255   = {alpha_q, 8'd0} - {8'd0, alpha_q};
  end

  // Memory
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem_q[PIX_AW'(pixel_index_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Request capture and product stages
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      index_q  <= pixel_index_i;
      addr_q   <= PIX_AW'(pixel_index_i);
      hit_q    <= (32'(pixel_index_i) < 32'(PIXELS));
      mode_q   <= blend_mode_i;
      src_q[0] <= src_red_i;
      src_q[1] <= src_green_i;
      src_q[2] <= src_blue_i;
      alpha_q  <= src_alpha_i;
      bright_q <= brightness_i;
    end
    if (state_q == S_READ) begin
      for (int c = 0; c < 3; c++) begin
        prod_sa_q[c] <= 16'(src_q[c]) * 16'(alpha_q);
      end
    end
    if (state_q == S_CALC) begin
      for (int c = 0; c < 3; c++) begin
        p_q[c]        <= div255(prod_sa_q[c] + ROUND_BIAS);
        prod_old_q[c] <= 16'(old_ch[c]) * 16'(mul_op);
      end
      prod_olda_q <= 16'(old_a) * 16'(~alpha_q);
    end
  end

  // Write-back arithmetic
  always_comb begin
    logic [8:0] sum;
    for (int c = 0; c < 3; c++) begin
      sum = {1'b0, old_ch[c]} + {1'b0, p_q[c]};
      case (mode_q)
        MODE_REPLACE: res_ch[c] = src_q[c];
        MODE_ADD:     res_ch[c] = sum[8] ? 8'hFF : sum[7:0];
        MODE_MAX:     res_ch[c] = (old_ch[c] > p_q[c]) ? old_ch[c] : p_q[c];
        default:      res_ch[c] = div255(prod_sa_q[c] + prod_old_q[c] + ROUND_BIAS);
      endcase
      rd_ch[c] = hit_q ? div255(prod_old_q[c] + ROUND_BIAS) : 8'd0;
    end
    case (mode_q) inside
      MODE_REPLACE:       res_a = alpha_q;
      MODE_ADD, MODE_MAX: res_a = (old_a > alpha_q) ? old_a : alpha_q;
      default:            res_a = div255(a255 + prod_olda_q + ROUND_BIAS);
    endcase
  end

  // Memory write port: clear sweep or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = 32'd0;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (state_q == S_WRITE && advance && hit_q) begin
      mem_we = 1'b1;
      if (kind_q == KIND_BLEND) begin
        mem_wdata = {res_a, res_ch[2], res_ch[1], res_ch[0]};
      end
    end
  end

  // Control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_index_d = out_index_q;
    out_ch_d    = out_ch_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + PIX_AW'(1);
        if (32'(clr_q) == PIXELS - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_CALC;
      S_CALC: state_d = S_WRITE;
      S_WRITE: begin
        if (advance) begin
          state_d = S_IDLE;
          if (kind_q == KIND_READOUT) begin
            out_valid_d = 1'b1;
            out_index_d = index_q;
            out_ch_d    = rd_ch;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_ch_q    <= '{default: 8'd0};
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      out_index_q <= out_index_d;
      out_ch_q    <= out_ch_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_red_o   = out_ch_q[0];
  assign out_green_o = out_ch_q[1];
  assign out_blue_o  = out_ch_q[2];

endmodule
`default_nettype wire

FILE: sv/lfc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_checker
// Port-level checks for the LED frame compositor, bound to the top level.
// ----------------------------------------------------------------------------
module lfc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       kind_i,
  input wire logic [8:0] pixel_index_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [8:0] out_index_o,
  input wire logic [7:0] out_red_o,
  input wire logic [7:0] out_green_o,
  input wire logic [7:0] out_blue_o
);
  import lfc_pkg::*;

  // One request in flight: ready stays low through the read, product and write-back states
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("request accepted while another is in flight");

  // A fresh result must follow an accepted readout request
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && kind_i == KIND_READOUT, 4))
    else $error("result without a matching readout request");

  // And carries that request's pixel index
  a_result_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_index_o == $past(pixel_index_i, 4))
    else $error("result index does not match readout request");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_index_o) &&
      $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o))
    else $error("stalled result changed");

endmodule

bind led_frame_compositor_unit lfc_checker u_lfc_checker (.*);
`default_nettype wire

FILE: dv/led_frame_compositor_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_frame_compositor_unit_tb
// Self-checking bench for the LED frame compositor. It runs a short directed
// pass over the blend modes and the edge values, then random frames. A frame
// is a burst of blends into a small pool of pixels followed by readouts of
// those pixels, with stray requests mixed in. A shadow copy of the pixel
// store predicts every readout, and each result is checked field by field.
// ----------------------------------------------------------------------------
module led_frame_compositor_unit_tb;
  import lfc_pkg::*;

  localparam int ITEM_TARGET = 1200;
  localparam int CYCLE_LIMIT = 400000; // sweep + items x worst gaps/stalls, x4
  localparam int LONG_HOLD   = 400;    // receiver hold-off, in cycles
  localparam int SETTLE      = 16;     // cycles past the last result

  typedef struct packed {
    logic [PIX_AW-1:0] index;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } readout_t;

  // Shadow pixel store plus the queue of readouts still owed by the block.
  class frame_store_model;
    logic [31:0] pixel_word [PIXELS];
    readout_t    readout_queue [$];
    int          mismatches;
    int          strays;
    int          reported;
    int          readouts;
    int          lit_readouts;
    int          blends_by_mode [4];

    function new();
      foreach (pixel_word[i]) pixel_word[i] = '0;
      mismatches = 0;
      strays = 0;
      reported = 0;
      readouts = 0;
      lit_readouts = 0;
      foreach (blends_by_mode[i]) blends_by_mode[i] = 0;
    endfunction

    // round(x * y / 255)
    function logic [7:0] frac_mult(logic [7:0] x, logic [7:0] y);
      int unsigned prod;
      prod = int'(x) * int'(y) + 127;
      return 8'(prod / 255);
    endfunction

    function int pending();
      return readout_queue.size();
    endfunction

    function void take_request(logic kind, logic [PIX_AW-1:0] idx, logic [1:0] mode,
                               logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                               logic [7:0] alpha, logic [7:0] bright);
      logic [31:0] word;
      logic [7:0]  src [3];
      logic [7:0]  res [4];
      logic [7:0]  old;
      logic [7:0]  prod;
      logic [7:0]  old_alpha;
      int unsigned acc;
      readout_t    exp_item;
      src[0] = red;
      src[1] = green;
      src[2] = blue;
      if (kind == KIND_READOUT) begin
        exp_item = '0;
        exp_item.index = idx;
        if (int'(idx) < PIXELS) begin
          word = pixel_word[idx];
          exp_item.red   = frac_mult(word[7:0], bright);
          exp_item.green = frac_mult(word[15:8], bright);
          exp_item.blue  = frac_mult(word[23:16], bright);
          pixel_word[idx] = '0;
        end
        readouts++;
        if (exp_item.red != 0 || exp_item.green != 0 || exp_item.blue != 0)
          lit_readouts++;
        readout_queue.push_back(exp_item);
        return;
      end
      if (int'(idx) >= PIXELS) return; // blend off the store is dropped
      blends_by_mode[mode]++;
      word = pixel_word[idx];
      old_alpha = word[31:24];
      for (int c = 0; c < 3; c++) begin
        old  = word[8*c +: 8];
        prod = frac_mult(src[c], alpha);
        case (mode)
          MODE_REPLACE: res[c] = src[c];
          MODE_ADD: begin
            acc = int'(old) + int'(prod);
            res[c] = (acc > 255) ? 8'hff : 8'(acc);
          end
          MODE_MAX: res[c] = (old > prod) ? old : prod;
          default: begin
            acc = (int'(src[c]) * int'(alpha) + int'(old) * (255 - int'(alpha)) + 127) / 255;
            res[c] = (acc > 255) ? 8'hff : 8'(acc);
          end
        endcase
      end
      case (mode)
        MODE_REPLACE: res[3] = alpha;
        MODE_ADD, MODE_MAX: res[3] = (old_alpha > alpha) ? old_alpha : alpha;
        default: begin
          acc = (int'(alpha) * 255 + int'(old_alpha) * (255 - int'(alpha)) + 127) / 255;
          res[3] = (acc > 255) ? 8'hff : 8'(acc);
        end
      endcase
      pixel_word[idx] = {res[3], res[2], res[1], res[0]};
    endfunction

    function void check_readout(logic [PIX_AW-1:0] idx, logic [7:0] red,
                                logic [7:0] green, logic [7:0] blue);
      readout_t exp_item;
      if (readout_queue.size() == 0) begin
        strays++;
        reported++;
        if (reported <= 10)
          $display("ERROR: unexpected readout idx=%0d rgb=%02h %02h %02h",
                   idx, red, green, blue);
        return;
      end
      exp_item = readout_queue.pop_front();
      if (exp_item.index != idx || exp_item.red != red ||
          exp_item.green != green || exp_item.blue != blue) begin
        mismatches++;
        reported++;
        if (reported <= 10)
          $display("ERROR: readout exp idx=%0d rgb=%02h %02h %02h, got idx=%0d rgb=%02h %02h %02h",
                   exp_item.index, exp_item.red, exp_item.green, exp_item.blue,
                   idx, red, green, blue);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block I/O; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              kind_i = KIND_BLEND;
  logic [PIX_AW-1:0] pixel_index_i = '0;
  logic [1:0]        blend_mode_i = MODE_REPLACE;
  logic [7:0]        src_red_i = '0;
  logic [7:0]        src_green_i = '0;
  logic [7:0]        src_blue_i = '0;
  logic [7:0]        src_alpha_i = '0;
  logic [7:0]        brightness_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PIX_AW-1:0] out_index_o;
  logic [7:0]        out_red_o;
  logic [7:0]        out_green_o;
  logic [7:0]        out_blue_o;

  frame_store_model store_model = new();

  int sent_count = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int hold_requests = 0;  // bumped by the sender, served by the receiver
  int holds_served = 0;

  led_frame_compositor_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .pixel_index_i (pixel_index_i),
    .blend_mode_i  (blend_mode_i),
    .src_red_i     (src_red_i),
    .src_green_i   (src_green_i),
    .src_blue_i    (src_blue_i),
    .src_alpha_i   (src_alpha_i),
    .brightness_i  (brightness_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_index_o   (out_index_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o)
  );

  // 10-unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $display("timeout after %0d cycles, %0d readouts outstanding",
               cycle_count, store_model.pending());
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Monitors: sample at the rising edge, where the driven side is stable
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      store_model.take_request(kind_i, pixel_index_i, blend_mode_i, src_red_i,
                               src_green_i, src_blue_i, src_alpha_i, brightness_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      store_model.check_readout(out_index_o, out_red_o, out_green_o, out_blue_o);
  end

  // --------------------------------------------------------------------------
  // Receiver: changes ready on falling edges. Phases of random length pick a
  // stall style; a hold request from the sender forces LONG_HOLD low cycles so
  // the output register fills and a readout backs up into the input.
  // --------------------------------------------------------------------------
  initial begin
    int phase_left;
    int style;
    int hold_left;
    int tick;
    phase_left = 0;
    style = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (phase_left == 0) begin
        style = $urandom_range(0, 3);
        phase_left = $urandom_range(32, 256);
      end
      phase_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (style)
          0: out_ready_i <= 1'b1;                          // no stalls
          1: out_ready_i <= 1'($urandom_range(0, 1));      // coin flip
          2: out_ready_i <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: out_ready_i <= ((tick % 5) != 0);       // periodic drop
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one request and hold it until taken.
  task automatic send_request(input logic kind, input logic [PIX_AW-1:0] idx,
                              input logic [1:0] mode, input logic [7:0] red,
                              input logic [7:0] green, input logic [7:0] blue,
                              input logic [7:0] alpha, input logic [7:0] bright);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    pixel_index_i <= idx;
    blend_mode_i  <= mode;
    src_red_i     <= red;
    src_green_i   <= green;
    src_blue_i    <= blue;
    src_alpha_i   <= alpha;
    brightness_i  <= bright;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // Same, but in bursts with random idle gaps in between.
  task automatic paced_request(input logic kind, input logic [PIX_AW-1:0] idx,
                               input logic [1:0] mode, input logic [7:0] red,
                               input logic [7:0] green, input logic [7:0] blue,
                               input logic [7:0] alpha, input logic [7:0] bright);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_request(kind, idx, mode, red, green, blue, alpha, bright);
  endtask

  // Stop offering until every readout owed has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (store_model.pending() != 0) @(negedge clk_i);
  endtask

  // Channel value leaning on the ends of the range.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Anything at all: any kind, any pixel, any field.
  task automatic noise_request();
    paced_request(1'($urandom_range(0, 1)), PIX_AW'($urandom_range(0, PIXELS - 1)),
                  2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [PIX_AW-1:0] pool [8];
    int pool_size;
    int round;
    int leftover;
    pool_size = 0;
    round = 0;

    // Hold reset, then release it on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fresh pixel reads zero; replace at both ends of the store
    send_request(KIND_READOUT, 0, MODE_REPLACE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_request(KIND_BLEND, 511, MODE_REPLACE, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00);
    send_request(KIND_READOUT, 511, MODE_OVER, 8'h12, 8'h34, 8'h56, 8'h78, 8'hff);
    // read after clear gives zero
    send_request(KIND_READOUT, 511, MODE_REPLACE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
    // add: saturation, alpha takes the max; brightness ignored on blends
    send_request(KIND_BLEND, 0, MODE_REPLACE, 8'hc0, 8'h10, 8'h00, 8'h40, 8'h55);
    send_request(KIND_BLEND, 0, MODE_ADD, 8'hff, 8'h80, 8'h01, 8'hff, 8'haa);
    send_request(KIND_BLEND, 0, MODE_ADD, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff);
    send_request(KIND_READOUT, 0, MODE_ADD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
    // max against a premultiplied source
    send_request(KIND_BLEND, 7, MODE_REPLACE, 8'h80, 8'h80, 8'h80, 8'hff, 8'h00);
    send_request(KIND_BLEND, 7, MODE_MAX, 8'hff, 8'h40, 8'h00, 8'h80, 8'h00);
    send_request(KIND_READOUT, 7, MODE_MAX, 8'hff, 8'hff, 8'hff, 8'hff, 8'h80);
    // over with transparent, opaque and half alpha
    send_request(KIND_BLEND, 300, MODE_REPLACE, 8'h20, 8'h40, 8'h60, 8'h80, 8'h00);
    send_request(KIND_BLEND, 300, MODE_OVER, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00);
    send_request(KIND_READOUT, 300, MODE_OVER, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
    send_request(KIND_BLEND, 300, MODE_OVER, 8'h11, 8'h22, 8'h33, 8'hff, 8'h00);
    send_request(KIND_BLEND, 300, MODE_OVER, 8'hff, 8'h00, 8'haa, 8'h7f, 8'h00);
    send_request(KIND_READOUT, 300, MODE_REPLACE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hc3);
    // zero brightness blanks a lit pixel
    send_request(KIND_BLEND, 256, MODE_REPLACE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_request(KIND_READOUT, 256, MODE_REPLACE, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00);
    send_request(KIND_READOUT, 256, MODE_REPLACE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff);

    // Random frames: blends into a small pool, then read the pool back
    while (sent_count < ITEM_TARGET) begin
      round++;
      if (round == 6 || round == 40) hold_requests++;
      if (round == 20 || round == 60) wait_drained();
      pool_size = $urandom_range(1, 8);
      for (int i = 0; i < pool_size; i++)
        pool[i] = PIX_AW'($urandom_range(0, PIXELS - 1));
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 9) == 0)
          noise_request();
        else
          paced_request(KIND_BLEND, pool[$urandom_range(0, pool_size - 1)],
                        2'($urandom_range(0, 3)), pick_level(), pick_level(),
                        pick_level(), pick_level(), 8'($urandom));
      end
      for (int i = 0; i < pool_size; i++) begin
        // an occasional pixel is left unread and carries into the next frame
        if ($urandom_range(0, 9) != 0)
          paced_request(KIND_READOUT, pool[i], 2'($urandom_range(0, 3)),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        pick_level());
        if ($urandom_range(0, 19) == 0) noise_request();
      end
    end

    // Drain, then let anything stray show up
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (store_model.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    leftover = store_model.pending();
    $display("Sent %0d requests: %0d readouts (%0d lit), blends replace/add/max/over %0d/%0d/%0d/%0d",
             sent_count, store_model.readouts, store_model.lit_readouts,
             store_model.blends_by_mode[0], store_model.blends_by_mode[1],
             store_model.blends_by_mode[2], store_model.blends_by_mode[3]);
    $display("Mismatches %0d, unexpected %0d, missing %0d, receiver holds %0d",
             store_model.mismatches, store_model.strays, leftover, holds_served);
    if (store_model.mismatches == 0 && store_model.strays == 0 && leftover == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
